// ----- rtl/dsh_pkg.sv -----
// Shared types and constants for the diamond-square heightmap generator.
`timescale 1ns / 1ps

package dsh_pkg;

  localparam int unsigned COORD_W     = 8;
  localparam int unsigned HEIGHT_W    = 32;
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned SIZE_W      = 4;
  localparam int unsigned HRED_W      = 17;
  localparam int unsigned AMP_W       = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 17;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE_LOG2        = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_HEIGHT_REDUCTION = 2'd1;

  // Configuration reset values.
  localparam logic [SIZE_W-1:0] SIZE_LOG2_RESET        = 4'd8;
  localparam logic [HRED_W-1:0] HEIGHT_REDUCTION_RESET = 17'd32768;

  // Input command codes.
  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    PH_DIAMOND,
    PH_SQ_FIRST,
    PH_SQ_SECOND,
    PH_DONE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_READ,
    ST_SUM,
    ST_CALC,
    ST_WR_FIRST,
    ST_WR_SECOND
  } eng_state_t;

  typedef struct packed {
    logic                       terrain_done;
    logic                       last_in_item;
    logic signed [HEIGHT_W-1:0] height;
    logic [COORD_W-1:0]         row;
    logic [COORD_W-1:0]         column;
  } result_t;

endpackage

// ----- rtl/dsh_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module dsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/dsh_result_fifo.sv -----
// Two-entry result queue that separates the engine from the output stream.
`timescale 1ns / 1ps

module dsh_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dsh_pkg::result_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output dsh_pkg::result_t  out_data
);

  dsh_pkg::result_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= in_data;
    end
  end

endmodule

// ----- rtl/dsh_engine.sv -----
// Read-modify-write sequencer: cell addressing, averaging, displacement and level stepping.
`timescale 1ns / 1ps

module dsh_engine #(
  parameter int LOG_SIDE = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [3:0]              cfg_size_log2,
  input  logic [16:0]             cfg_height_reduction,
  input  logic                    in_valid,
  input  logic                    in_cmd,
  input  logic [15:0]             in_frac,
  output logic                    in_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output dsh_pkg::result_t        out_result,
  output logic                    ram_wr_en,
  output logic [2*LOG_SIDE-1:0]   ram_wr_addr,
  output logic [31:0]             ram_wr_data,
  output logic                    ram_rd_en,
  output logic [2*LOG_SIDE-1:0]   ram_rd_addr,
  input  logic [31:0]             ram_rd_data
);

  localparam int CW = LOG_SIDE;
  localparam int LW = LOG_SIDE + 1;
  localparam int AW = 2 * LOG_SIDE;
  localparam logic [3:0] LogMax = 4'(LOG_SIDE);
  localparam int RstLog = (int'(dsh_pkg::SIZE_LOG2_RESET) > LOG_SIDE) ? LOG_SIDE :
                          (int'(dsh_pkg::SIZE_LOG2_RESET) < 1) ? 1 :
                          int'(dsh_pkg::SIZE_LOG2_RESET);
  localparam logic [LW-1:0] RstSide = LW'(1) << RstLog;
  localparam logic [31:0]   RstAmp  = 32'(RstSide) << 15;

  dsh_pkg::eng_state_t state, state_next;

  // Generation state.
  logic [LW-1:0]     level_size;
  logic [CW-1:0]     cell_column;
  logic [CW-1:0]     cell_row;
  dsh_pkg::phase_t   step_phase;
  logic [31:0]       current_amplitude;
  logic signed [31:0] held_left_mid;

  // Per-item working registers.
  logic [1:0]         rd_cnt;
  logic               rd_pending;
  logic signed [33:0] sum;
  logic [32:0]        smp_prod;
  logic signed [31:0] new_height;
  logic [AW-1:0]      clr_cnt;

  logic take;
  logic take_sample;
  logic take_clear;
  logic final_write;

  // Current side and mask.
  logic [3:0]    size_l;
  logic [LW-1:0] side;
  logic [CW-1:0] m;

  always_comb begin
    if (cfg_size_log2 < 4'd1) begin
      size_l = 4'd1;
    end else if (cfg_size_log2 > LogMax) begin
      size_l = LogMax;
    end else begin
      size_l = cfg_size_log2;
    end
  end

  assign side = LW'(1) << size_l;
  assign m    = CW'(side - LW'(1));

  // Cell coordinates and neighbors, wrapped to the current side.
  logic [CW-1:0] x, y, nx, ny, nx_w, ny_w, mx, my, pmx, pmy, half_c;
  logic [LW-1:0] nx_sum, ny_sum, half;

  assign x      = cell_column & m;
  assign y      = cell_row & m;
  assign half   = level_size >> 1;
  assign half_c = half[CW-1:0];
  assign nx_sum = LW'(x) + level_size;
  assign ny_sum = LW'(y) + level_size;
  assign nx_w   = nx_sum[CW-1:0] & m;
  assign ny_w   = ny_sum[CW-1:0] & m;
  // A neighbor that wraps past the edge sticks to the last row or column.
  assign nx     = (nx_w < x) ? m : nx_w;
  assign ny     = (ny_w < y) ? m : ny_w;
  assign mx     = (x + half_c) & m;
  assign my     = (y + half_c) & m;
  assign pmx    = (x - half_c) & m;
  assign pmy    = (y - half_c) & m;

  // Read address selection by phase and read slot.
  logic [1:0]    rd_idx;
  logic [CW-1:0] rd_x, rd_y;

  assign rd_idx = (state == dsh_pkg::ST_IDLE) ? 2'd0 : rd_cnt;

  always_comb begin
    rd_x = x;
    rd_y = y;
    case (step_phase)
      dsh_pkg::PH_DIAMOND: begin
        case (rd_idx)
          2'd0: begin rd_x = x;  rd_y = y;  end
          2'd1: begin rd_x = nx; rd_y = y;  end
          2'd2: begin rd_x = x;  rd_y = ny; end
          default: begin rd_x = nx; rd_y = ny; end
        endcase
      end
      dsh_pkg::PH_SQ_FIRST: begin
        case (rd_idx)
          2'd0: begin rd_x = x;   rd_y = y;  end
          2'd1: begin rd_x = mx;  rd_y = my; end
          2'd2: begin rd_x = x;   rd_y = ny; end
          default: begin rd_x = pmx; rd_y = my; end
        endcase
      end
      default: begin
        case (rd_idx)
          2'd0: begin rd_x = x;  rd_y = y;   end
          2'd1: begin rd_x = mx; rd_y = my;  end
          2'd2: begin rd_x = nx; rd_y = y;   end
          default: begin rd_x = mx; rd_y = pmy; end
        endcase
      end
    endcase
  end

  assign ram_rd_addr = {rd_y, rd_x};

  // Advance to the next cell, pass or level.
  logic [LW-1:0]   col_sum, row_sum, level_half;
  logic            col_wrap, row_wrap;
  logic [48:0]     amp_full;
  logic [33:0]     amp_rnd;
  logic [31:0]     amp_upd;
  dsh_pkg::phase_t adv_base, adv_phase;
  logic [CW-1:0]   adv_col, adv_row;
  logic [LW-1:0]   adv_level;
  logic [31:0]     adv_amp;

  assign col_sum    = LW'(cell_column) + level_size;
  assign row_sum    = LW'(cell_row) + level_size;
  assign col_wrap   = (col_sum >= side);
  assign row_wrap   = (row_sum >= side);
  assign level_half = level_size >> 1;
  assign amp_full   = 49'(current_amplitude) * 49'(cfg_height_reduction);
  assign amp_rnd    = 34'((50'(amp_full) + 50'd32768) >> 16);
  assign amp_upd    = (amp_rnd > 34'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : amp_rnd[31:0];
  // The second square sample steps from the first-square phase.
  assign adv_base   = (step_phase == dsh_pkg::PH_SQ_SECOND) ? dsh_pkg::PH_SQ_FIRST
                                                             : step_phase;

  always_comb begin
    adv_col   = col_wrap ? '0 : col_sum[CW-1:0];
    adv_row   = cell_row;
    adv_level = level_size;
    adv_amp   = current_amplitude;
    adv_phase = adv_base;
    if (col_wrap) begin
      adv_row = row_wrap ? '0 : row_sum[CW-1:0];
      if (row_wrap) begin
        if (adv_base == dsh_pkg::PH_DIAMOND) begin
          adv_phase = dsh_pkg::PH_SQ_FIRST;
        end else begin
          adv_level = level_half;
          adv_amp   = amp_upd;
          adv_phase = (level_half == '0) ? dsh_pkg::PH_DONE : dsh_pkg::PH_DIAMOND;
        end
      end
    end
  end

  // Height: floor of the four-cell mean plus the displacement, saturated.
  logic signed [31:0] avg;
  logic signed [34:0] disp;
  logic signed [35:0] total;
  logic signed [31:0] calc_height;

  assign avg   = sum[33:2];
  assign disp  = $signed({2'b00, smp_prod}) - $signed({3'b000, current_amplitude});
  assign total = 36'(avg) + 36'(disp);

  always_comb begin
    if (total[35:31] == 5'b00000 || total[35:31] == 5'b11111) begin
      calc_height = total[31:0];
    end else if (total[35]) begin
      calc_height = 32'sh8000_0000;
    end else begin
      calc_height = 32'sh7FFF_FFFF;
    end
  end

  assign take        = (state == dsh_pkg::ST_IDLE) && in_valid;
  assign take_clear  = take && (in_cmd == dsh_pkg::CMD_CLEAR);
  assign take_sample = take && (in_cmd == dsh_pkg::CMD_SAMPLE) &&
                       (step_phase != dsh_pkg::PH_DONE) && (level_size != '0);
  assign final_write = out_ready &&
                       (((state == dsh_pkg::ST_WR_FIRST) &&
                         (step_phase == dsh_pkg::PH_DIAMOND)) ||
                        (state == dsh_pkg::ST_WR_SECOND));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dsh_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  logic [CW-1:0] wr_x, wr_y;

  always_comb begin
    state_next   = state;
    in_ready     = 1'b0;
    ram_rd_en    = 1'b0;
    ram_wr_en    = 1'b0;
    out_valid    = 1'b0;
    wr_x         = mx;
    wr_y         = my;
    ram_wr_data  = new_height;
    out_result.terrain_done = 1'b0;
    out_result.last_in_item = 1'b1;
    unique case (state)
      dsh_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (take_clear) begin
          state_next = dsh_pkg::ST_CLEAR;
        end else if (take_sample) begin
          ram_rd_en  = 1'b1;
          state_next = dsh_pkg::ST_READ;
        end
      end
      dsh_pkg::ST_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = '0;
        if (clr_cnt == '1) begin
          state_next = dsh_pkg::ST_IDLE;
        end
      end
      dsh_pkg::ST_READ: begin
        ram_rd_en = 1'b1;
        if (rd_cnt == 2'd3) begin
          state_next = dsh_pkg::ST_SUM;
        end
      end
      dsh_pkg::ST_SUM: begin
        state_next = dsh_pkg::ST_CALC;
      end
      dsh_pkg::ST_CALC: begin
        state_next = (step_phase == dsh_pkg::PH_SQ_FIRST) ? dsh_pkg::ST_IDLE
                                                          : dsh_pkg::ST_WR_FIRST;
      end
      dsh_pkg::ST_WR_FIRST: begin
        out_valid = 1'b1;
        if (step_phase != dsh_pkg::PH_DIAMOND) begin
          wr_y = y;
          out_result.last_in_item = 1'b0;
        end
        if (out_ready) begin
          ram_wr_en  = 1'b1;
          state_next = (step_phase == dsh_pkg::PH_DIAMOND) ? dsh_pkg::ST_IDLE
                                                           : dsh_pkg::ST_WR_SECOND;
        end
      end
      dsh_pkg::ST_WR_SECOND: begin
        out_valid   = 1'b1;
        wr_x        = x;
        wr_y        = my;
        ram_wr_data = held_left_mid;
        out_result.terrain_done = (adv_phase == dsh_pkg::PH_DONE);
        if (out_ready) begin
          ram_wr_en  = 1'b1;
          state_next = dsh_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dsh_pkg::ST_IDLE;
      end
    endcase
    ram_wr_addr = (state == dsh_pkg::ST_CLEAR) ? clr_cnt : {wr_y, wr_x};
    out_result.height = ram_wr_data;
    out_result.column = 8'(wr_x);
    out_result.row    = 8'(wr_y);
  end

  // Control and generation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_size        <= RstSide;
      cell_column       <= '0;
      cell_row          <= '0;
      step_phase        <= dsh_pkg::PH_DIAMOND;
      current_amplitude <= RstAmp;
      clr_cnt           <= '0;
      rd_cnt            <= 2'd1;
      rd_pending        <= 1'b0;
    end else begin
      rd_pending <= ram_rd_en;
      if (take_clear) begin
        level_size        <= side;
        cell_column       <= '0;
        cell_row          <= '0;
        step_phase        <= dsh_pkg::PH_DIAMOND;
        current_amplitude <= 32'(side) << 15;
        clr_cnt           <= '0;
      end
      if (state == dsh_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == dsh_pkg::ST_IDLE) begin
        rd_cnt <= 2'd1;
      end else if (state == dsh_pkg::ST_READ) begin
        rd_cnt <= rd_cnt + 2'd1;
      end
      if (state == dsh_pkg::ST_CALC && step_phase == dsh_pkg::PH_SQ_FIRST) begin
        step_phase <= dsh_pkg::PH_SQ_SECOND;
      end
      if (final_write) begin
        cell_column       <= adv_col;
        cell_row          <= adv_row;
        level_size        <= adv_level;
        current_amplitude <= adv_amp;
        step_phase        <= adv_phase;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (take_sample) begin
      sum      <= '0;
      // The full product is kept before the shift; only the top part is stored.
      smp_prod <= 33'((49'({current_amplitude, 1'b0}) * 49'(in_frac)) >> 16);
    end else if (rd_pending) begin
      sum <= sum + {{2{ram_rd_data[31]}}, ram_rd_data};
    end
    if (state == dsh_pkg::ST_CALC) begin
      if (step_phase == dsh_pkg::PH_SQ_FIRST) begin
        held_left_mid <= calc_height;
      end else begin
        new_height <= calc_height;
      end
    end
  end

endmodule

// ----- rtl/diamond_square_heightmap_generator.sv -----
// Top level of the diamond-square heightmap generator.
// This block runs diamond-square terrain generation over a square grid of signed Q16.16
// heights with side 2^size_log2 (clamped to 1..LOG_SIDE), held in one on-chip RAM. Every
// input transaction is either a clear (tuser 0), which zeroes the whole grid and restarts
// at the full level size with amplitude side/2, or a random sample (tuser 1, tdata an
// unsigned Q0.16 fraction) that drives one step. A diamond cell takes one sample and
// writes one cell; a square cell takes two samples, the first gives nothing out and the
// second writes the top-mid and then the left-mid cell. Each written cell comes out as
// one result transaction carrying column, row and the saturated height; tlast marks the
// last result of an input, tuser marks the final write of the whole generation. After the
// last level further samples are swallowed until a clear. Each sample passes through the
// four grid reads on the single RAM read port, a state that finishes the sum, one that
// forms the height and one write per result. A one-entry input register accepts the
// next transaction while the engine works, and a two-entry result queue lets results
// wait, the engine stalling in its write states only while the queue is full. A clear,
// and likewise reset, sweeps every RAM row, during which the engine takes no input;
// configuration writes are taken at any time and should be made only while the block
// is idle.
`timescale 1ns / 1ps

module diamond_square_heightmap_generator #(
  parameter int LOG_SIDE = 8
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] random_fraction
  input  logic        s_axis_tuser,   // [0] cmd
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [7:0] column, [15:8] row, [47:16] height
  output logic        m_axis_tlast,   // last_in_item
  output logic        m_axis_tuser,   // [0] terrain_done
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int AW = 2 * LOG_SIDE;

  // Configuration registers.
  logic [3:0]  size_log2;
  logic [16:0] height_reduction;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2        <= dsh_pkg::SIZE_LOG2_RESET;
      height_reduction <= dsh_pkg::HEIGHT_REDUCTION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dsh_pkg::CFG_SIZE_LOG2:        size_log2        <= cfg_data[3:0];
        dsh_pkg::CFG_HEIGHT_REDUCTION: height_reduction <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input holding register: a new transaction is taken as soon as the engine frees it.
  logic        buf_valid;
  logic        buf_cmd;
  logic [15:0] buf_frac;
  logic        eng_in_ready;
  logic        eng_take;

  assign eng_take      = buf_valid && eng_in_ready;
  assign s_axis_tready = !buf_valid || eng_in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      buf_valid <= 1'b1;
    end else if (eng_take) begin
      buf_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      buf_cmd  <= s_axis_tuser;
      buf_frac <= s_axis_tdata;
    end
  end

  // Engine, grid RAM and result queue.
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [31:0]      ram_wr_data;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [31:0]      ram_rd_data;
  logic             eng_out_valid;
  logic             eng_out_ready;
  dsh_pkg::result_t eng_result;
  dsh_pkg::result_t q_result;

  dsh_engine #(
    .LOG_SIDE(LOG_SIDE)
  ) u_engine (
    .clk                  (clk),
    .rst                  (rst),
    .cfg_size_log2        (size_log2),
    .cfg_height_reduction (height_reduction),
    .in_valid             (buf_valid),
    .in_cmd               (buf_cmd),
    .in_frac              (buf_frac),
    .in_ready             (eng_in_ready),
    .out_valid            (eng_out_valid),
    .out_ready            (eng_out_ready),
    .out_result           (eng_result),
    .ram_wr_en            (ram_wr_en),
    .ram_wr_addr          (ram_wr_addr),
    .ram_wr_data          (ram_wr_data),
    .ram_rd_en            (ram_rd_en),
    .ram_rd_addr          (ram_rd_addr),
    .ram_rd_data          (ram_rd_data)
  );

  dsh_ram #(
    .WIDTH(32),
    .DEPTH(1 << AW)
  ) u_grid (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  dsh_result_fifo u_results (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (eng_out_valid),
    .in_ready  (eng_out_ready),
    .in_data   (eng_result),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (q_result)
  );

  assign m_axis_tdata = {q_result.height, q_result.row, q_result.column};
  assign m_axis_tlast = q_result.last_in_item;
  assign m_axis_tuser = q_result.terrain_done;

endmodule
